// File: src/client_admission_filter_core_defines.svh
// Assertion macros for the client admission filter.
// Included by the top level; depends on nothing else.
`ifndef CLIENT_ADMISSION_FILTER_CORE_DEFINES_SVH
`define CLIENT_ADMISSION_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define CAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("caf assertion failed");

// Next-cycle implication, checked on every rising edge outside reset
`define CAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("caf assertion failed");

`endif

// File: src/caf_pkg.sv
// Shared widths, reset values, register indexes and the cell control struct
// of the client admission filter. Depends on nothing.
`timescale 1ns / 1ps

package caf_pkg;

   localparam int ADDR_W          = 32;
   localparam int PORT_W          = 16;
   localparam int LEN_W           = 12;
   localparam int KEY_W           = ADDR_W + PORT_W;
   localparam int CAP_W           = 7;
   localparam int COUNT_OUT_W     = 7;
   localparam int TOTAL_W         = 64;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int TABLE_DEPTH_DEF = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Configuration register indexes; the spare index writes nothing
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIENT_CAP  = 2'd0,
      CSR_ECHO_ENABLE = 2'd1,
      CSR_SPARE       = 2'd3
   } csr_index_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic shift;   // take the neighbor's key, cell 0 takes the new key
      logic probe;   // compare the held key against the probe key
   } cell_ctl_type;

endpackage

// File: src/caf_cell.sv
// One slot of the admitted-key chain: holds a key, compares it against
// the probe key and hands it to the next slot on insertion. Uses caf_pkg.
`timescale 1ns / 1ps

module caf_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  caf_pkg::cell_ctl_type      ctl,
   input  logic [CNT_W-1:0]           count,
   input  logic [caf_pkg::KEY_W-1:0]  probe_key,
   input  logic [caf_pkg::KEY_W-1:0]  shift_key,
   output logic [caf_pkg::KEY_W-1:0]  held_key,
   output logic                       hit
);
   import caf_pkg::*;

   localparam logic [CNT_W-1:0] SLOT = CNT_W'(CELL_INDEX);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             hit_ff;
   logic             hit_in;
   logic             occupied;

   // A slot holds a live key only below the current fill count
   assign occupied = SLOT < count;

   // Shift the chain by one slot on insertion
   assign key_in = ctl.shift ? shift_key : key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // Register the match result during the probe cycle
   assign hit_in = ctl.probe ? (occupied && (key_ff == probe_key)) : hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign held_key = key_ff;
   assign hit      = hit_ff;

endmodule

// File: src/client_admission_filter_core.sv
// Client admission filter: a chain of key cells plus the decision,
// counter and register logic. Uses caf_pkg, caf_cell and the defines header.
// A taken transaction moves through the probe and decide states; its result strobe is registered.
// All cells probe the key together, and the block decides in the next cycle.
// busy is high only in the probe cycle; a new transaction may start in the decide cycle.
// Reset (synchronous): clears key count and totals, cap to 64, echo off; no table sweep.
`timescale 1ns / 1ps
`include "client_admission_filter_core_defines.svh"

module client_admission_filter_core #(
   parameter int TABLE_DEPTH = caf_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [caf_pkg::ADDR_W-1:0]       req_source_address,
   input  logic [caf_pkg::PORT_W-1:0]       req_source_port,
   input  logic [caf_pkg::LEN_W-1:0]        req_packet_length,
   output logic                             rsp_valid,
   output logic                             rsp_admitted,
   output logic                             rsp_echo_request,
   output logic                             rsp_new_client,
   output logic [caf_pkg::COUNT_OUT_W-1:0]  rsp_client_count,
   output logic [caf_pkg::TOTAL_W-1:0]      rsp_served_packets,
   output logic [caf_pkg::TOTAL_W-1:0]      rsp_served_bytes,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [caf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [caf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import caf_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PROBE  = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic                     accept;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TOTAL_W-1:0]       pkt_ff, pkt_in;
   logic [TOTAL_W-1:0]       byte_ff, byte_in;
   logic [CAP_W-1:0]         cap_ff, cap_in;
   logic                     echo_ff, echo_in;
   cell_ctl_type             ctl;
   logic [KEY_W-1:0]         held_key [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   hit_vec;
   logic                     deciding;
   logic                     hit_any;
   logic                     room;
   logic                     insert;
   logic                     ok;
   logic [CMP_W-1:0]         cnt_ext;
   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         depth_ext;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_admitted_ff, rsp_echo_ff, rsp_new_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;
   logic [TOTAL_W-1:0]       rsp_pkt_ff, rsp_byte_ff;

   // Hold off a new transaction only while the cells probe
   assign busy   = (state_ff == ST_PROBE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_PROBE;
         end
         ST_PROBE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = accept ? ST_PROBE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the transaction key and length
   assign key_in = accept ? {req_source_address, req_source_port} : key_ff;
   assign len_in = accept ? req_packet_length : len_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      len_ff <= len_in;
   end

   // Key chain: cell 0 takes the new key, each cell feeds the next
   assign ctl.probe = (state_ff == ST_PROBE);
   assign ctl.shift = insert;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         caf_cell #(
            .CELL_INDEX(i),
            .CNT_W     (CNT_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .count    (count_ff),
            .probe_key(key_ff),
            .shift_key(key_ff),
            .held_key (held_key[i]),
            .hit      (hit_vec[i])
         );
      end else begin : g_body
         caf_cell #(
            .CELL_INDEX(i),
            .CNT_W     (CNT_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .count    (count_ff),
            .probe_key(key_ff),
            .shift_key(held_key[i-1]),
            .held_key (held_key[i]),
            .hit      (hit_vec[i])
         );
      end
   end

   // Decide: known key, or room below the effective cap
   assign deciding  = (state_ff == ST_DECIDE);
   assign hit_any   = |hit_vec;
   assign cnt_ext   = CMP_W'(count_ff);
   assign cap_ext   = CMP_W'(cap_ff);
   assign depth_ext = CMP_W'(TABLE_DEPTH);
   assign room      = (cnt_ext < cap_ext) && (cnt_ext < depth_ext);
   assign insert    = deciding && !hit_any && room;
   assign ok        = hit_any || room;

   // Advance count and totals on admission
   always_comb begin
      count_in = count_ff;
      pkt_in   = pkt_ff;
      byte_in  = byte_ff;
      if (insert) begin
         count_in = count_ff + 1'b1;
      end
      if (deciding && ok) begin
         pkt_in  = pkt_ff + 1'b1;
         byte_in = byte_ff + {{(TOTAL_W-LEN_W){1'b0}}, len_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pkt_ff   <= '0;
         byte_ff  <= '0;
      end else begin
         count_ff <= count_in;
         pkt_ff   <= pkt_in;
         byte_ff  <= byte_in;
      end
   end

   // Configuration writes, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cap_in  = cap_ff;
      echo_in = echo_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CLIENT_CAP: begin
               cap_in = csr_data[CAP_W-1:0];
            end
            CSR_ECHO_ENABLE: begin
               echo_in = csr_data[0];
            end
            default: begin
               cap_in  = cap_ff;
               echo_in = echo_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         echo_ff <= 1'b0;
      end else begin
         cap_ff  <= cap_in;
         echo_ff <= echo_in;
      end
   end

   // Register the result transaction
   assign count_wide   = {{COUNT_OUT_W{1'b0}}, count_in};
   assign rsp_valid_in = deciding;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deciding) begin
         rsp_admitted_ff <= ok;
         rsp_echo_ff     <= ok && echo_ff;
         rsp_new_ff      <= insert;
         rsp_count_ff    <= count_wide[COUNT_OUT_W-1:0];
         rsp_pkt_ff      <= pkt_in;
         rsp_byte_ff     <= byte_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_admitted       = rsp_admitted_ff;
   assign rsp_echo_request   = rsp_echo_ff;
   assign rsp_new_client     = rsp_new_ff;
   assign rsp_client_count   = rsp_count_ff;
   assign rsp_served_packets = rsp_pkt_ff;
   assign rsp_served_bytes   = rsp_byte_ff;

   // Checks on sequencing and result consistency
   `CAF_ASSERT_NEXT(a_accept_probe, clock, reset, accept, busy)
   `CAF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= TABLE_DEPTH)
   `CAF_ASSERT_NOW(a_new_admitted, clock, reset, rsp_valid && rsp_new_client, rsp_admitted)
   `CAF_ASSERT_NEXT(a_insert_count, clock, reset, insert, count_ff == $past(count_ff) + 1'b1)

endmodule

// File: tb/client_admission_filter_core_test.sv
// Self-checking testbench for client_admission_filter_core: directed table, then
// random traffic in several cap/echo phases. Depends on caf_pkg and the core RTL.
`timescale 1ns / 1ps

module client_admission_filter_core_test;
   import caf_pkg::*;

   localparam int DEPTH     = TABLE_DEPTH_DEF;
   localparam int POOL_SIZE = 96;
   localparam int MAX_SHOWN = 10;

   typedef enum logic {ROW_PACKET, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic                   admitted;
      logic                   echo_request;
      logic                   new_client;
      logic [COUNT_OUT_W-1:0] client_count;
      logic [TOTAL_W-1:0]     served_packets;
      logic [TOTAL_W-1:0]     served_bytes;
   } verdict_type;

   typedef struct {
      row_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
      logic [LEN_W-1:0]  len;
      csr_index_type     idx;
      logic [31:0]       data;
      bit                typed;
      verdict_type       verdict;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ADDR_W-1:0]       req_source_address;
   logic [PORT_W-1:0]       req_source_port;
   logic [LEN_W-1:0]        req_packet_length;
   logic                    rsp_valid;
   logic                    rsp_admitted;
   logic                    rsp_echo_request;
   logic                    rsp_new_client;
   logic [COUNT_OUT_W-1:0]  rsp_client_count;
   logic [TOTAL_W-1:0]      rsp_served_packets;
   logic [TOTAL_W-1:0]      rsp_served_bytes;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // Admission state as the block should hold it
   logic [KEY_W-1:0]   admitted_keys [DEPTH];
   int                 admitted_total;
   logic [TOTAL_W-1:0] packet_sum;
   logic [TOTAL_W-1:0] byte_sum;
   logic [CAP_W-1:0]   cap_limit;
   logic               echo_on;

   verdict_type   pending_verdicts [$];
   stim_row_type  stim_table [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int         error_count;

   client_admission_filter_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_source_address (req_source_address),
      .req_source_port    (req_source_port),
      .req_packet_length  (req_packet_length),
      .rsp_valid          (rsp_valid),
      .rsp_admitted       (rsp_admitted),
      .rsp_echo_request   (rsp_echo_request),
      .rsp_new_client     (rsp_new_client),
      .rsp_client_count   (rsp_client_count),
      .rsp_served_packets (rsp_served_packets),
      .rsp_served_bytes   (rsp_served_bytes),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Decide one packet against the table and advance the totals
   function automatic verdict_type admit_packet(logic [ADDR_W-1:0] addr,
                                                logic [PORT_W-1:0] port,
                                                logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] key;
      int               limit;
      bit               known;
      bit               fresh;
      verdict_type      v;
      key   = {addr, port};
      limit = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
      known = 1'b0;
      fresh = 1'b0;
      for (int i = 0; i < admitted_total; i++) begin
         if (admitted_keys[i] == key) known = 1'b1;
      end
      if (!known && admitted_total < limit) begin
         admitted_keys[admitted_total] = key;
         admitted_total++;
         fresh = 1'b1;
      end
      if (known || fresh) begin
         packet_sum = packet_sum + 1;
         byte_sum   = byte_sum + TOTAL_W'(len);
      end
      v.admitted       = known || fresh;
      v.echo_request   = (known || fresh) && echo_on;
      v.new_client     = fresh;
      v.client_count   = COUNT_OUT_W'(admitted_total);
      v.served_packets = packet_sum;
      v.served_bytes   = byte_sum;
      return v;
   endfunction

   // Compare every result strobe with the oldest pending verdict
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_admitted, rsp_echo_request, rsp_new_client, rsp_client_count,
                rsp_served_packets, rsp_served_bytes};
         if (pending_verdicts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("%0t: unexpected result transaction", $realtime);
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_SHOWN) begin
                  $display("%0t: mismatch adm/echo/new/count expected %0d/%0d/%0d/%0d",
                           $realtime, want.admitted, want.echo_request,
                           want.new_client, want.client_count);
                  $display("   got %0d/%0d/%0d/%0d", got.admitted, got.echo_request,
                           got.new_client, got.client_count);
                  $display("   packets expected %0d got %0d, bytes expected %0d got %0d",
                           want.served_packets, got.served_packets,
                           want.served_bytes, got.served_bytes);
               end
            end
         end
      end
   end

   // Table rows
   task automatic packet_row(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                             logic [LEN_W-1:0] l);
      stim_row_type r;
      r = '{kind: ROW_PACKET, addr: a, port: p, len: l, idx: CSR_CLIENT_CAP,
            data: '0, typed: 1'b0, verdict: '0};
      stim_table.insert(stim_table.size(), r);
   endtask

   task automatic packet_row_typed(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                                   logic [LEN_W-1:0] l, int adm, int echo,
                                   int fresh, int count, longint pkts, longint bytes);
      stim_row_type r;
      r = '{kind: ROW_PACKET, addr: a, port: p, len: l, idx: CSR_CLIENT_CAP,
            data: '0, typed: 1'b1, verdict: '0};
      r.verdict = {1'(adm), 1'(echo), 1'(fresh), COUNT_OUT_W'(count),
                   TOTAL_W'(pkts), TOTAL_W'(bytes)};
      stim_table.insert(stim_table.size(), r);
   endtask

   task automatic write_row(csr_index_type i, logic [31:0] d);
      stim_row_type r;
      r = '{kind: ROW_WRITE, addr: '0, port: '0, len: '0, idx: i,
            data: d, typed: 1'b0, verdict: '0};
      stim_table.insert(stim_table.size(), r);
   endtask

   // Drop start and idle for a gap of length n
   task automatic hold_off(int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Drop start and wait until every pending result has come
   task automatic drain_results();
      hold_off(1);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Offer one packet and predict its verdict once the block takes it
   task automatic send_packet(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                              logic [LEN_W-1:0] l, bit typed, verdict_type typed_verdict);
      verdict_type v;
      @(negedge clock);
      start              = 1'b1;
      req_source_address = a;
      req_source_port    = p;
      req_packet_length  = l;
      do @(posedge clock); while (busy);
      v = admit_packet(a, p, l);
      pending_verdicts.insert(pending_verdicts.size(), typed ? typed_verdict : v);
   endtask

   // Write a register once the block is idle
   task automatic write_register(csr_index_type i, logic [31:0] d);
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = i;
      csr_data  = d;
      do @(posedge clock); while (!csr_ready);
      case (i)
         CSR_CLIENT_CAP:  cap_limit = d[CAP_W-1:0];
         CSR_ECHO_ENABLE: echo_on   = d[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int               phase_caps [7];
      bit               phase_echo [7];
      int               pick;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;

      start              = 1'b0;
      req_source_address = '0;
      req_source_port    = '0;
      req_packet_length  = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      reset              = 1'b1;
      error_count        = 0;
      admitted_total     = 0;
      packet_sum         = '0;
      byte_sum           = '0;
      cap_limit          = CAP_RESET;
      echo_on            = 1'b0;

      // Directed: extremes, key formation, echo, zero cap, cap above depth,
      // cap lowered below count, spare index, high data bits and long lengths
      packet_row_typed(32'h0, 16'h0, 12'd0, 1, 0, 1, 1, 1, 0);
      packet_row_typed(32'hFFFF_FFFF, 16'hFFFF, 12'hFFF, 1, 0, 1, 2, 2, 4095);
      packet_row_typed(32'h0, 16'h0, 12'd2048, 1, 0, 0, 2, 3, 6143);
      write_row(CSR_ECHO_ENABLE, 32'd1);
      packet_row_typed(32'hFFFF_FFFF, 16'hFFFF, 12'd1, 1, 1, 0, 2, 4, 6144);
      write_row(CSR_CLIENT_CAP, 32'd0);
      packet_row_typed(32'h1234_5678, 16'h9ABC, 12'd100, 0, 0, 0, 2, 4, 6144);
      packet_row_typed(32'h0, 16'h0, 12'd5, 1, 1, 0, 2, 5, 6149);
      write_row(CSR_CLIENT_CAP, 32'd3);
      packet_row_typed(32'h1, 16'h0, 12'd10, 1, 1, 1, 3, 6, 6159);
      packet_row_typed(32'h0, 16'h1, 12'd20, 0, 0, 0, 3, 6, 6159);
      packet_row(32'h1, 16'h0, 12'd0);
      write_row(CSR_ECHO_ENABLE, 32'd0);
      write_row(CSR_CLIENT_CAP, 32'd127);
      packet_row_typed(32'h0, 16'h1, 12'd7, 1, 0, 1, 4, 8, 6166);
      packet_row_typed(32'h8000_0000, 16'h8000, 12'd2048, 1, 0, 1, 5, 9, 8214);
      write_row(CSR_CLIENT_CAP, 32'd65);
      packet_row(32'h7FFF_FFFF, 16'h7FFF, 12'd0);
      write_row(CSR_SPARE, 32'hFFFF_FFFF);
      write_row(CSR_CLIENT_CAP, 32'hFFFF_FF85);
      packet_row_typed(32'hDEAD_BEEF, 16'h1234, 12'd9, 0, 0, 0, 6, 10, 8214);
      packet_row(32'h8000_0000, 16'h8000, 12'hFFF);

      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), 16'($urandom())};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_WRITE) begin
            write_register(stim_table[i].idx, stim_table[i].data);
         end else begin
            send_packet(stim_table[i].addr, stim_table[i].port, stim_table[i].len,
                        stim_table[i].typed, stim_table[i].verdict);
            hold_off(gap_length());
         end
      end

      // Random phases: the table only grows, so caps mix tight values with open ones
      phase_caps = '{10, 0, 20, 127, 64, 1, 100};
      phase_echo = '{1, 0, 1, 0, 1, 0, 1};
      for (int ph = 0; ph < 7; ph++) begin
         write_register(CSR_CLIENT_CAP, 32'(phase_caps[ph]));
         write_register(CSR_ECHO_ENABLE, 32'(phase_echo[ph]));
         for (int n = 0; n < 86; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 85 && admitted_total > 0)
               key = admitted_keys[$urandom_range(0, admitted_total - 1)];
            else
               key = {$urandom(), 16'($urandom())};
            len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(2049, 4095))
                                              : LEN_W'($urandom_range(0, 2048));
            send_packet(key[KEY_W-1:PORT_W], key[PORT_W-1:0], len, 1'b0, '0);
            // Back-to-back in some phases, one full drain mid-phase
            if (ph == 2 && n == 40)
               drain_results();
            else if (ph != 0 && ph != 4)
               hold_off(gap_length());
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
